### hdl/acs_pkg.sv
// Shared types, widths and codes for the audio chunk splitter.
`default_nettype none

package acs_pkg;

  localparam int unsigned OffW      = 48;
  localparam int unsigned SizeW     = 18;
  localparam int unsigned SampW     = 32;
  localparam int unsigned CodecW    = 2;
  localparam int unsigned BppW      = 10;
  localparam int unsigned ChW       = 4;
  localparam int unsigned UnitW     = BppW + ChW;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 10;
  localparam int unsigned MaxPieces = 64;
  localparam int unsigned PieceCntW = $clog2(MaxPieces);

  localparam int unsigned DefBaseChunk = 4096;
  localparam int unsigned DefDtsChunk  = 65536;

  localparam logic [CodecW-1:0] CodecOther = 2'd0;
  localparam logic [CodecW-1:0] CodecPcm   = 2'd1;
  localparam logic [CodecW-1:0] CodecDts   = 2'd2;

  localparam logic [CfgIdxW-1:0] CfgCodec = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgBpp   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgChan  = 2'd2;

  typedef struct packed {
    logic [CodecW-1:0] codec;
    logic [BppW-1:0]   bpp;
    logic [ChW-1:0]    ch;
  } lim_cfg_t;

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StLimit = 4'b0010,
    StShare = 4'b0100,
    StEmit  = 4'b1000
  } state_e;

  typedef enum logic [1:0] {
    KindPass  = 2'd0,
    KindBig   = 2'd1,
    KindSplit = 2'd2
  } kind_e;

endpackage

`default_nettype wire

### hdl/acs_entry_if.sv
// Valid/ready channels for index entries and for output pieces.
`default_nettype none

interface acs_entry_if;
  import acs_pkg::*;
  logic             valid;
  logic             ready;
  logic [OffW-1:0]  entry_offset;
  logic [SizeW-1:0] entry_size;
  logic [SampW-1:0] entry_samples;

  modport source(output valid, entry_offset, entry_size, entry_samples, input ready);
  modport sink(input valid, entry_offset, entry_size, entry_samples, output ready);
endinterface

interface acs_piece_if;
  import acs_pkg::*;
  logic             valid;
  logic             ready;
  logic [OffW-1:0]  piece_offset;
  logic [SizeW-1:0] piece_size;
  logic [SampW-1:0] piece_samples;
  logic             was_split;
  logic             too_big;
  logic             last_piece;

  modport source(output valid, piece_offset, piece_size, piece_samples, was_split, too_big,
                 last_piece, input ready);
  modport sink(input valid, piece_offset, piece_size, piece_samples, was_split, too_big,
               last_piece, output ready);
endinterface

`default_nettype wire

### hdl/acs_limit.sv
// Chunk limit unit: bit-serial remainder for pcm packet alignment.
`default_nettype none

module acs_limit #(
  parameter int unsigned BaseChunk = acs_pkg::DefBaseChunk,
  parameter int unsigned DtsChunk  = acs_pkg::DefDtsChunk,
  parameter int unsigned LimW      = $clog2(((BaseChunk > DtsChunk) ? BaseChunk : DtsChunk) + 1)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire acs_pkg::lim_cfg_t cfg_i,
  output logic                   done_o,
  output logic [LimW-1:0]        lim_o
);
  import acs_pkg::*;

  localparam int unsigned CntW = $clog2(LimW + 1);
  localparam logic [LimW-1:0] BaseLim = LimW'((BaseChunk / 32) * 32);
  localparam logic [LimW-1:0] DtsLim  = LimW'(DtsChunk);

  logic             busy_q, done_q, reduce_q;
  logic [CntW-1:0]  cnt_q;
  logic [LimW-1:0]  sh_q, lim0_q;
  logic [UnitW-1:0] rem_q, rem_d, unit_q, unit_d;
  logic [UnitW:0]   r2;
  logic             fits;
  logic [LimW+UnitW-1:0] cut_w;
  logic [LimW-1:0]  cut;

  assign unit_d = UnitW'(cfg_i.bpp) * UnitW'(cfg_i.ch);
  assign r2     = {rem_q, sh_q[LimW-1]};
  assign fits   = r2 >= {1'b0, unit_q};
  assign rem_d  = fits ? UnitW'(r2 - {1'b0, unit_q}) : r2[UnitW-1:0];
  assign cut_w  = {{UnitW{1'b0}}, lim0_q} - {{LimW{1'b0}}, rem_q};
  assign cut    = cut_w[LimW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(LimW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      lim0_q   <= (cfg_i.codec == CodecDts) ? DtsLim : BaseLim;
      sh_q     <= (cfg_i.codec == CodecDts) ? DtsLim : BaseLim;
      reduce_q <= (cfg_i.codec == CodecPcm) && (cfg_i.bpp > BppW'(1));
      unit_q   <= unit_d;
      rem_q    <= '0;
    end else if (busy_q) begin
      sh_q  <= {sh_q[LimW-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign lim_o  = (reduce_q && (unit_q != '0) && (cut != '0)) ? cut : lim0_q;

endmodule

`default_nettype wire

### hdl/acs_share.sv
// Share unit: shift-add multiply then restoring divide, one bit per cycle.
`default_nettype none

module acs_share #(
  parameter int unsigned BaseChunk = acs_pkg::DefBaseChunk,
  parameter int unsigned DtsChunk  = acs_pkg::DefDtsChunk,
  parameter int unsigned LimW      = $clog2(((BaseChunk > DtsChunk) ? BaseChunk : DtsChunk) + 1)
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [acs_pkg::SampW-1:0]  samples_i,
  input  wire logic [acs_pkg::SizeW-1:0]  size_i,
  input  wire logic [LimW-1:0]            lim_i,
  output logic                            done_o,
  output logic [acs_pkg::SampW-1:0]       share_o
);
  import acs_pkg::*;

  localparam int unsigned PW   = SampW + LimW;
  localparam int unsigned CntW = $clog2(PW + 1);

  logic             mul_q, div_q, done_q;
  logic [CntW-1:0]  cnt_q;
  logic [PW-1:0]    acc_q;
  logic [LimW-1:0]  lsh_q;
  logic [SampW-1:0] samp_q, quo_q;
  logic [SizeW-1:0] size_q, rem_q, rem_d;
  logic [SizeW:0]   r2;
  logic             fits;

  assign r2    = {rem_q, acc_q[PW-1]};
  assign fits  = r2 >= {1'b0, size_q};
  assign rem_d = fits ? SizeW'(r2 - {1'b0, size_q}) : r2[SizeW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_q  <= 1'b0;
      div_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        mul_q <= 1'b1;
        cnt_q <= CntW'(LimW);
      end else if (mul_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          mul_q <= 1'b0;
          div_q <= 1'b1;
          cnt_q <= CntW'(PW);
        end
      end else if (div_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          div_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q  <= '0;
      lsh_q  <= lim_i;
      samp_q <= samples_i;
      size_q <= size_i;
      rem_q  <= '0;
      quo_q  <= '0;
    end else if (mul_q) begin
      acc_q <= {acc_q[PW-2:0], 1'b0} + (lsh_q[LimW-1] ? PW'(samp_q) : '0);
      lsh_q <= {lsh_q[LimW-2:0], 1'b0};
    end else if (div_q) begin
      acc_q <= {acc_q[PW-2:0], 1'b0};
      rem_q <= rem_d;
      quo_q <= {quo_q[SampW-2:0], fits};
    end
  end

  assign done_o  = done_q;
  assign share_o = quo_q;

endmodule

`default_nettype wire

### hdl/audio_chunk_splitter.sv
// Audio chunk splitter top level: config registers, sequencer, piece emitter.
//
// Usage: index entries arrive on entry_i (valid/ready), pieces leave on piece_o.
// Each entry yields one word (passthrough or dts too-big error) or up to 64
// split pieces, the final one flagged by last_piece. Config (codec class,
// bytes per packet, channel count) is written through cfg_we_i/cfg_idx_i/
// cfg_data_i while the block is idle.
// Each entry first gets its limit from a serial remainder over the LimW bits
// of the larger chunk size (17 by default); a split entry then goes through
// the bit-serial multiply and divide that give the per-piece sample share.
// Pieces then go out one per cycle while the receiver is ready. One entry is
// in work at a time; the next entry is taken once the last piece of the
// previous one sits in the output register.
// Reset clears the sequencer and output valid and restores codec class 0,
// bytes per packet 1 and channel count 1.
// A stalled receiver holds the output word; emission waits, nothing is lost.
`default_nettype none

module audio_chunk_splitter #(
  parameter int unsigned BaseChunk = acs_pkg::DefBaseChunk,
  parameter int unsigned DtsChunk  = acs_pkg::DefDtsChunk
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [acs_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [acs_pkg::CfgDataW-1:0]  cfg_data_i,
  acs_entry_if.sink                          entry_i,
  acs_piece_if.source                        piece_o
);
  import acs_pkg::*;

  localparam int unsigned LimW = $clog2(((BaseChunk > DtsChunk) ? BaseChunk : DtsChunk) + 1);
  localparam int unsigned CW   = (LimW > SizeW) ? LimW : SizeW;
  localparam logic [CW-1:0] DtsCmp = CW'(DtsChunk);

  logic [CodecW-1:0] codec_q;
  logic [BppW-1:0]   bpp_q;
  logic [ChW-1:0]    ch_q;

  state_e state_q;
  kind_e  kind_q, kind_d;
  logic   in_acc, lim_done, share_done, share_start, load, more;
  logic [LimW-1:0]      lim_val, lim_q;
  logic [SampW-1:0]     share_val, share_q;
  logic [OffW-1:0]      off_q;
  logic [SizeW-1:0]     left_q;
  logic [SampW-1:0]     rest_q;
  logic [PieceCntW-1:0] cnt_q;
  lim_cfg_t             lim_cfg;

  logic             out_v_q, split_o_q, big_o_q, last_o_q;
  logic [OffW-1:0]  off_o_q;
  logic [SizeW-1:0] size_o_q;
  logic [SampW-1:0] samp_o_q;

  assign lim_cfg = '{codec: codec_q, bpp: bpp_q, ch: ch_q};
  assign in_acc  = entry_i.valid && entry_i.ready;
  assign entry_i.ready = (state_q == StIdle);

  assign share_start = (state_q == StLimit) && lim_done && (kind_d == KindSplit);
  assign load = (state_q == StEmit) && (!out_v_q || piece_o.ready);
  assign more = (CW'(left_q) > CW'(lim_q)) && (cnt_q != PieceCntW'(MaxPieces - 1));

  acs_limit #(.BaseChunk(BaseChunk), .DtsChunk(DtsChunk), .LimW(LimW)) u_limit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(in_acc),
    .cfg_i  (lim_cfg),
    .done_o (lim_done),
    .lim_o  (lim_val)
  );

  acs_share #(.BaseChunk(BaseChunk), .DtsChunk(DtsChunk), .LimW(LimW)) u_share (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (share_start),
    .samples_i(rest_q),
    .size_i   (left_q),
    .lim_i    (lim_val),
    .done_o   (share_done),
    .share_o  (share_val)
  );

  // kind is settled combinationally against the fresh limit
  always_comb begin
    if ((codec_q == CodecDts) && (CW'(left_q) > DtsCmp)) begin
      kind_d = KindBig;
    end else if (CW'(left_q) <= CW'(lim_val)) begin
      kind_d = KindPass;
    end else begin
      kind_d = KindSplit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codec_q <= CodecOther;
      bpp_q   <= BppW'(1);
      ch_q    <= ChW'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgCodec: codec_q <= cfg_data_i[CodecW-1:0];
        CfgBpp:   bpp_q   <= cfg_data_i[BppW-1:0];
        CfgChan:  ch_q    <= cfg_data_i[ChW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      kind_q  <= KindPass;
      out_v_q <= 1'b0;
    end else begin
      if (load) begin
        out_v_q <= 1'b1;
      end else if (piece_o.ready) begin
        out_v_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_acc) begin
            state_q <= StLimit;
          end
        end
        StLimit: begin
          kind_q <= kind_d;
          if (lim_done) begin
            state_q <= (kind_d == KindSplit) ? StShare : StEmit;
          end
        end
        StShare: begin
          if (share_done) begin
            state_q <= StEmit;
          end
        end
        StEmit: begin
          if (load && !((kind_q == KindSplit) && more)) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      off_q  <= entry_i.entry_offset;
      left_q <= entry_i.entry_size;
      rest_q <= entry_i.entry_samples;
      cnt_q  <= '0;
    end
    if ((state_q == StLimit) && lim_done) begin
      lim_q <= lim_val;
    end
    if (share_done) begin
      share_q <= share_val;
    end
    if (load) begin
      case (kind_q)
        KindBig: begin
          off_o_q   <= '0;
          size_o_q  <= '0;
          samp_o_q  <= '0;
          split_o_q <= 1'b0;
          big_o_q   <= 1'b1;
          last_o_q  <= 1'b1;
        end
        KindSplit: begin
          split_o_q <= 1'b1;
          big_o_q   <= 1'b0;
          off_o_q   <= off_q;
          if (more) begin
            size_o_q <= SizeW'(lim_q);
            samp_o_q <= share_q;
            last_o_q <= 1'b0;
            off_q    <= off_q + OffW'(lim_q);
            left_q   <= left_q - SizeW'(lim_q);
            rest_q   <= rest_q - share_q;
            cnt_q    <= cnt_q + 1'b1;
          end else begin
            size_o_q <= left_q;
            samp_o_q <= rest_q;
            last_o_q <= 1'b1;
          end
        end
        default: begin
          off_o_q   <= off_q;
          size_o_q  <= left_q;
          samp_o_q  <= rest_q;
          split_o_q <= 1'b0;
          big_o_q   <= 1'b0;
          last_o_q  <= 1'b1;
        end
      endcase
    end
  end

  assign piece_o.valid         = out_v_q;
  assign piece_o.piece_offset  = off_o_q;
  assign piece_o.piece_size    = size_o_q;
  assign piece_o.piece_samples = samp_o_q;
  assign piece_o.was_split     = split_o_q;
  assign piece_o.too_big       = big_o_q;
  assign piece_o.last_piece    = last_o_q;

endmodule

`default_nettype wire

### hdl/acs_checker.sv
// Port-level checker for the audio chunk splitter, bound to the top level.
`default_nettype none

module acs_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      in_valid_i,
  input wire logic                      in_ready_i,
  input wire logic                      out_valid_i,
  input wire logic                      out_ready_i,
  input wire logic [acs_pkg::SizeW-1:0] out_size_i,
  input wire logic                      out_split_i,
  input wire logic                      out_big_i,
  input wire logic                      out_last_i
);
  import acs_pkg::*;

  logic in_acc, out_acc, out_end;
  logic [1:0] pend_q;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;
  assign out_end = out_acc && out_last_i;

  // entries accepted whose final word is still outstanding
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + {1'b0, in_acc} - {1'b0, out_end};
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output word dropped while stalled");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_end |-> pend_q != 2'd0)
    else $error("final word without an accepted entry");

  a_one_ahead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> pend_q < 2'd2)
    else $error("entry accepted while two are outstanding");

  a_big_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_big_i |-> out_last_i && !out_split_i && out_size_i == '0)
    else $error("malformed too-big word");

  a_pass_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_split_i |-> out_last_i)
    else $error("unsplit word not final");

endmodule

bind audio_chunk_splitter acs_checker u_acs_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (entry_i.valid),
  .in_ready_i (entry_i.ready),
  .out_valid_i(piece_o.valid),
  .out_ready_i(piece_o.ready),
  .out_size_i (piece_o.piece_size),
  .out_split_i(piece_o.was_split),
  .out_big_i  (piece_o.too_big),
  .out_last_i (piece_o.last_piece)
);

`default_nettype wire
